// ----- design/rkst_pkg.sv -----
`timescale 1ns / 1ps
package rkst_pkg;

  // port widths
  localparam int IN_KEY_W     = 52;
  localparam int IN_SLOT_W    = 5;
  localparam int OUT_STATUS_W = 3;
  localparam int OUT_SLOT_W   = 5;
  localparam int OUT_COUNT_W  = 16;

  // widest values the chain carries, over the whole parameter range
  localparam int MAX_KEY_W = 64;
  localparam int MAX_CNT_W = 32;
  localparam int MAX_IDX_W = 8;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int KEY_BITS_DEF   = 52;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [OUT_STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_FULL     = 3'd2,
    ST_HELD     = 3'd3,
    ST_FREED    = 3'd4,
    ST_BADPUT   = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_SEARCH
  } state_t;

  // request held steady for the whole search
  typedef struct packed {
    logic                 put;
    logic [MAX_KEY_W-1:0] key;
    logic [IN_SLOT_W-1:0] sel;
    logic                 noncoh;
  } req_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 match;
    logic [MAX_IDX_W-1:0] match_idx;
    logic [MAX_CNT_W-1:0] match_users;
    logic [MAX_CNT_W-1:0] match_nc;
    logic                 free;
    logic [MAX_IDX_W-1:0] free_idx;
  } token_t;

  // update broadcast to every cell, taken by the addressed one
  typedef struct packed {
    logic                 valid;
    logic [MAX_IDX_W-1:0] idx;
    logic                 in_use;
    logic                 write_key;
    logic [MAX_CNT_W-1:0] users;
    logic [MAX_CNT_W-1:0] nc;
  } commit_t;

endpackage

// ----- design/refcounted_key_slot_table.sv -----
`timescale 1ns / 1ps
// refcounted_key_slot_table
// A table of SLOT_COUNT slots, each holding a key, a user count and a
// noncoherent user count, kept in a chain of identical cells.
// Input channel: a transaction is accepted on a rising edge with start high
// and busy low. in_req_type 0 is a get (look up in_root_addr, add a user or
// allocate the lowest free slot), 1 is a put (release one user of in_slot).
// Result channel: out_valid is high for exactly one cycle per request with
// out_status, out_slot_index, out_user_count and out_all_coherent. The
// receiver cannot stall, so the result is simply dropped onto the ports.
// Timing: a search token steps one cell per clock down the chain, from the
// LAUNCH state on through SEARCH; the result strobe is registered from the
// token leaving the last cell, and busy drops in the cycle of the strobe.
// One request is in flight at a time: a new request is taken only once the
// token has walked the whole cell chain and the result has been set out.
// Reset (rst_n low, synchronous): all slots are free with zero counts, no
// request is in flight and no strobe is pending.
module refcounted_key_slot_table #(
  parameter int SLOT_COUNT = rkst_pkg::SLOT_COUNT_DEF,
  parameter int KEY_BITS   = rkst_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = rkst_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [rkst_pkg::IN_KEY_W-1:0]      in_root_addr,
  input  logic [rkst_pkg::IN_SLOT_W-1:0]     in_slot,
  input  logic                               in_coherent,
  output logic                               out_valid,
  output logic [rkst_pkg::OUT_STATUS_W-1:0]  out_status,
  output logic [rkst_pkg::OUT_SLOT_W-1:0]    out_slot_index,
  output logic [rkst_pkg::OUT_COUNT_W-1:0]   out_user_count,
  output logic                               out_all_coherent
);

  rkst_pkg::req_t    req;
  rkst_pkg::commit_t commit;
  rkst_pkg::token_t  tok [SLOT_COUNT+1];

  rkst_ctrl #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_root_addr     (in_root_addr),
    .in_slot          (in_slot),
    .in_coherent      (in_coherent),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_user_count   (out_user_count),
    .out_all_coherent (out_all_coherent),
    .req              (req),
    .commit           (commit),
    .tok_launch       (tok[0]),
    .tok_last         (tok[SLOT_COUNT])
  );

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    rkst_cell #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req),
      .commit  (commit),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

endmodule

// ----- design/rkst_cell.sv -----
`timescale 1ns / 1ps
module rkst_cell #(
  parameter int KEY_BITS   = rkst_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = rkst_pkg::COUNT_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rkst_pkg::req_t    req,
  input  rkst_pkg::commit_t commit,
  input  rkst_pkg::token_t  tok_in,
  output rkst_pkg::token_t  tok_out
);

  localparam logic [rkst_pkg::MAX_IDX_W-1:0] MY_IDX = rkst_pkg::MAX_IDX_W'(CELL_IDX);

  logic                  in_use_r, in_use_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] users_r, users_nxt;
  logic [COUNT_BITS-1:0] nc_r, nc_nxt;
  rkst_pkg::token_t      tok_r, tok_nxt;

  logic held;
  logic hit;
  logic sel_me;

  assign held   = in_use_r && (users_r != '0);
  assign hit    = tok_in.valid && held &&
                  (req.put ? (rkst_pkg::MAX_IDX_W'(req.sel) == MY_IDX)
                           : (key_r == KEY_BITS'(req.key)));
  assign sel_me = commit.valid && (commit.idx == MY_IDX);

  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.match && hit) begin
      tok_nxt.match       = 1'b1;
      tok_nxt.match_idx   = MY_IDX;
      tok_nxt.match_users = rkst_pkg::MAX_CNT_W'(users_r);
      tok_nxt.match_nc    = rkst_pkg::MAX_CNT_W'(nc_r);
    end
    // lowest free slot wins: earlier cells claim it first
    if (tok_in.valid && !tok_in.free && !in_use_r) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = MY_IDX;
    end
  end

  always_comb begin
    in_use_nxt = in_use_r;
    users_nxt  = users_r;
    nc_nxt     = nc_r;
    if (sel_me) begin
      in_use_nxt = commit.in_use;
      users_nxt  = COUNT_BITS'(commit.users);
      nc_nxt     = COUNT_BITS'(commit.nc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      users_r  <= '0;
      nc_r     <= '0;
      tok_r    <= '0;
    end else begin
      in_use_r <= in_use_nxt;
      users_r  <= users_nxt;
      nc_r     <= nc_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_me && commit.write_key) begin
      key_r <= KEY_BITS'(req.key);
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- design/rkst_ctrl.sv -----
`timescale 1ns / 1ps
module rkst_ctrl #(
  parameter int KEY_BITS   = rkst_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = rkst_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [rkst_pkg::IN_KEY_W-1:0]      in_root_addr,
  input  logic [rkst_pkg::IN_SLOT_W-1:0]     in_slot,
  input  logic                               in_coherent,
  output logic                               out_valid,
  output logic [rkst_pkg::OUT_STATUS_W-1:0]  out_status,
  output logic [rkst_pkg::OUT_SLOT_W-1:0]    out_slot_index,
  output logic [rkst_pkg::OUT_COUNT_W-1:0]   out_user_count,
  output logic                               out_all_coherent,
  output rkst_pkg::req_t                     req,
  output rkst_pkg::commit_t                  commit,
  output rkst_pkg::token_t                   tok_launch,
  input  rkst_pkg::token_t                   tok_last
);

  localparam logic [rkst_pkg::MAX_CNT_W-1:0] CNT_MAX =
    rkst_pkg::MAX_CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

  rkst_pkg::state_t state_r, state_nxt;
  rkst_pkg::req_t   req_r;

  logic                               out_valid_r;
  rkst_pkg::status_t                  out_status_r;
  logic [rkst_pkg::OUT_SLOT_W-1:0]    out_slot_index_r;
  logic [rkst_pkg::OUT_COUNT_W-1:0]   out_user_count_r;
  logic                               out_all_coherent_r;

  logic accept;
  logic finish;

  rkst_pkg::status_t                 dec_status;
  logic [rkst_pkg::MAX_IDX_W-1:0]    dec_idx;
  logic [rkst_pkg::MAX_CNT_W-1:0]    dec_users;
  logic [rkst_pkg::MAX_CNT_W-1:0]    dec_nc;
  logic                              dec_allc;
  logic                              dec_write;
  logic                              dec_in_use;
  logic                              dec_key;
  logic [rkst_pkg::MAX_CNT_W-1:0]    noncoh_ext;

  assign accept = start && !busy;
  assign finish = (state_r == rkst_pkg::S_SEARCH) && tok_last.valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rkst_pkg::S_IDLE:   if (start) state_nxt = rkst_pkg::S_LAUNCH;
      rkst_pkg::S_LAUNCH: state_nxt = rkst_pkg::S_SEARCH;
      rkst_pkg::S_SEARCH: if (tok_last.valid) state_nxt = rkst_pkg::S_IDLE;
      default:            state_nxt = rkst_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy       = 1'b1;
    tok_launch = '0;
    unique case (state_r)
      rkst_pkg::S_IDLE:   busy = 1'b0;
      rkst_pkg::S_LAUNCH: tok_launch.valid = 1'b1;
      rkst_pkg::S_SEARCH: busy = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  assign noncoh_ext = rkst_pkg::MAX_CNT_W'(req_r.noncoh);

  // decision once the token has seen every slot
  always_comb begin
    dec_status = rkst_pkg::ST_FULL;
    dec_idx    = tok_last.match_idx;
    dec_users  = tok_last.match_users;
    dec_nc     = tok_last.match_nc;
    dec_allc   = (tok_last.match_nc == '0);
    dec_write  = 1'b0;
    dec_in_use = 1'b1;
    dec_key    = 1'b0;
    if (!req_r.put) begin
      if (tok_last.match) begin
        if (tok_last.match_users >= CNT_MAX ||
            (req_r.noncoh && tok_last.match_nc >= CNT_MAX)) begin
          dec_status = rkst_pkg::ST_OVERFLOW;
        end else begin
          dec_status = rkst_pkg::ST_FOUND;
          dec_users  = tok_last.match_users + 1'b1;
          dec_nc     = tok_last.match_nc + noncoh_ext;
          dec_allc   = (dec_nc == '0);
          dec_write  = 1'b1;
        end
      end else if (tok_last.free) begin
        dec_status = rkst_pkg::ST_ALLOC;
        dec_idx    = tok_last.free_idx;
        dec_users  = rkst_pkg::MAX_CNT_W'(1);
        dec_nc     = noncoh_ext;
        dec_allc   = !req_r.noncoh;
        dec_write  = 1'b1;
        dec_key    = 1'b1;
      end else begin
        dec_idx   = '0;
        dec_users = '0;
        dec_nc    = '0;
        dec_allc  = 1'b0;
      end
    end else begin
      if (!tok_last.match) begin
        // slot out of range or not held: echo the requested slot
        dec_status = rkst_pkg::ST_BADPUT;
        dec_idx    = rkst_pkg::MAX_IDX_W'(req_r.sel);
        dec_users  = '0;
        dec_nc     = '0;
        dec_allc   = 1'b0;
      end else if (tok_last.match_users > rkst_pkg::MAX_CNT_W'(1)) begin
        if (req_r.noncoh && tok_last.match_nc == '0) begin
          dec_status = rkst_pkg::ST_BADPUT;
        end else begin
          dec_status = rkst_pkg::ST_HELD;
          dec_users  = tok_last.match_users - 1'b1;
          dec_nc     = tok_last.match_nc - noncoh_ext;
          dec_allc   = (dec_nc == '0);
          dec_write  = 1'b1;
        end
      end else begin
        dec_status = rkst_pkg::ST_FREED;
        dec_users  = '0;
        dec_nc     = '0;
        dec_allc   = 1'b1;
        dec_write  = 1'b1;
        dec_in_use = 1'b0;
      end
    end
  end

  always_comb begin
    commit.valid     = finish && dec_write;
    commit.idx       = dec_idx;
    commit.in_use    = dec_in_use;
    commit.write_key = dec_key;
    commit.users     = dec_users;
    commit.nc        = dec_nc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rkst_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.put    <= in_req_type;
      req_r.key    <= rkst_pkg::MAX_KEY_W'(KEY_BITS'(in_root_addr));
      req_r.sel    <= in_slot;
      req_r.noncoh <= !in_coherent;
    end
    if (finish) begin
      out_status_r       <= dec_status;
      out_slot_index_r   <= dec_idx[rkst_pkg::OUT_SLOT_W-1:0];
      out_user_count_r   <= dec_users[rkst_pkg::OUT_COUNT_W-1:0];
      out_all_coherent_r <= dec_allc;
    end
  end

  assign req              = req_r;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_slot_index_r;
  assign out_user_count   = out_user_count_r;
  assign out_all_coherent = out_all_coherent_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.valid |-> state_r == rkst_pkg::S_SEARCH)
    else $error("search token arrived outside search");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == rkst_pkg::ST_FULL) |->
      (out_slot_index_r == '0 && out_user_count_r == '0 && !out_all_coherent_r))
    else $error("table full result carries slot data");

  a_freed_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == rkst_pkg::ST_FREED) |->
      (out_user_count_r == '0 && out_all_coherent_r))
    else $error("freed slot reports users");

endmodule
